>>> hw/rtl/rsenc_pkg.sv
// Shared types, constants and GF(2^8) helpers for the Reed-Solomon encoder.
`default_nettype none
package rsenc_pkg;

	// number of parity symbols per codeword
	localparam int NPAR = 12;

	localparam int SYM_W   = 8;
	localparam int DRAIN_W = (NPAR > 2) ? $clog2(NPAR) : 1;

	// field reduction constant for x^8+x^4+x^3+x^2+1
	localparam logic [SYM_W-1:0] GF_POLY = 8'h1d;

	// longest message that still fits a 255-symbol codeword
	localparam logic [SYM_W-1:0] MAX_MSG = SYM_W'(255 - NPAR);
	localparam logic [SYM_W-1:0] CNT_SAT = 8'hff;

	typedef logic [NPAR:0][SYM_W-1:0] gen_t;

	// one result item
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             is_parity;
		logic             word_end;
		logic             overlong;
	} item_t;

	typedef enum logic {
		ST_MSG,
		ST_PARITY
	} state_t;

	// GF(2^8) multiply, shift-and-add over the 8 bits of b
	function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
		input logic [SYM_W-1:0] b);
		logic [SYM_W-1:0] x;
		logic [SYM_W-1:0] p;
		logic             carry;
		x = '0;
		p = a;
		for (int i = 0; i < SYM_W; i++) begin
			if (b[i]) begin
				x = x ^ p;
			end
			carry = p[SYM_W-1];
			p = {p[SYM_W-2:0], 1'b0};
			if (carry) begin
				p = p ^ GF_POLY;
			end
		end
		return x;
	endfunction

	// generator g(x) = prod (x + alpha^i), i = 0..NPAR-1, alpha = 2
	function automatic gen_t build_gen();
		gen_t             g;
		logic [SYM_W-1:0] root;
		g    = '0;
		g[0] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < NPAR; i++) begin
			for (int j = NPAR; j >= 1; j--) begin
				if (j <= i + 1) begin
					g[j] = g[j-1] ^ gf_mul(g[j], root);
				end
			end
			g[0] = gf_mul(g[0], root);
			root = gf_mul(root, 8'h02);
		end
		return g;
	endfunction

	localparam gen_t GEN_COEF = build_gen();

endpackage
`default_nettype wire

>>> hw/rtl/rsenc_cell.sv
// One LFSR stage of the encoder: holds one remainder symbol.
`default_nettype none
module rsenc_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,      // shift this cycle
	input  wire logic                        mul_en,  // add feedback term (message item)
	input  wire logic [rsenc_pkg::SYM_W-1:0] fb,
	input  wire logic [rsenc_pkg::SYM_W-1:0] coef,
	input  wire logic [rsenc_pkg::SYM_W-1:0] prev,    // lower-degree neighbor
	output logic      [rsenc_pkg::SYM_W-1:0] q
);

	logic [rsenc_pkg::SYM_W-1:0] term;
	logic [rsenc_pkg::SYM_W-1:0] par_q;

	// feedback product; zero while parity drains out
	assign term = mul_en ? rsenc_pkg::gf_mul(fb, coef) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= '0;
		end else if (en) begin
			par_q <= prev ^ term;
		end
	end

	assign q = par_q;

endmodule
`default_nettype wire

>>> hw/rtl/rsenc_out_buf.sv
// Two-entry output buffer: output register plus skid entry.
`default_nettype none
module rsenc_out_buf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rsenc_pkg::item_t push_item,
	output logic                  full,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rsenc_pkg::item_t      out_item
);

	logic [1:0]       cnt_q;
	logic             pop;
	rsenc_pkg::item_t e0_q;
	rsenc_pkg::item_t e1_q;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign out_item  = e0_q;

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// payload entries
	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (push) begin
					e0_q <= push_item;
				end
			end
			2'd1: begin
				if (push && pop) begin
					e0_q <= push_item;
				end else if (push) begin
					e1_q <= push_item;
				end
			end
			2'd2: begin
				if (pop) begin
					e0_q <= e1_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/rs_gf256_systematic_encoder_core.sv
// Top level of the systematic Reed-Solomon GF(2^8) encoder.
//
// Message symbols enter on the slave stream highest degree first, s_tlast on
// the final one. Each symbol is passed through at once and clocked into a row
// of NPAR LFSR cells, one item per cycle while the output buffer is not full.
// After the last symbol the same cell row shifts its remainder out as NPAR
// parity items, highest degree first, with m_tlast on the final one; the shift
// leaves the cells cleared for the next word. While parity drains s_tready is
// low. A two-entry output buffer decouples s_tready from m_tready. m_tuser[1]
// (overlong) is set from the symbol that pushes a message past 255-NPAR
// symbols through the end of that codeword.
`default_nettype none
module rs_gf256_systematic_encoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] msg_symbol
	input  wire logic       s_tlast,   // msg_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [7:0] out_symbol
	output logic      [1:0] m_tuser,   // [0] is_parity, [1] overlong
	output logic            m_tlast    // word_end
);

	localparam int NPAR  = rsenc_pkg::NPAR;
	localparam int SYM_W = rsenc_pkg::SYM_W;

	rsenc_pkg::state_t state_q, state_d;

	logic [SYM_W-1:0]              cnt_q;
	logic                          err_q;
	logic [rsenc_pkg::DRAIN_W-1:0] drain_cnt_q;

	logic                          buf_full;
	logic                          acc;
	logic                          drain_step;
	logic                          drain_done;
	logic                          push;
	logic [SYM_W-1:0]              fb;
	logic [SYM_W-1:0]              cnt_inc;
	logic                          err_n;
	logic [NPAR-1:0][SYM_W-1:0]    par;
	rsenc_pkg::item_t              push_item;
	rsenc_pkg::item_t              out_item;

	// handshake and drain control
	always_comb begin
		s_tready   = 1'b0;
		drain_step = 1'b0;
		unique case (state_q)
			rsenc_pkg::ST_MSG:    s_tready   = !buf_full;
			rsenc_pkg::ST_PARITY: drain_step = !buf_full;
			default: begin
			end
		endcase
	end

	assign acc        = s_tvalid && s_tready;
	assign drain_done = drain_step && (drain_cnt_q == '0);
	assign push       = acc || drain_step;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsenc_pkg::ST_MSG:    if (acc && s_tlast) state_d = rsenc_pkg::ST_PARITY;
			rsenc_pkg::ST_PARITY: if (drain_done) state_d = rsenc_pkg::ST_MSG;
			default:              state_d = rsenc_pkg::ST_MSG;
		endcase
	end

	// length tracking, saturating count
	assign cnt_inc = (cnt_q == rsenc_pkg::CNT_SAT) ? cnt_q : cnt_q + 1'b1;
	assign err_n   = err_q || (cnt_inc > rsenc_pkg::MAX_MSG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsenc_pkg::ST_MSG;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			drain_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				err_q <= err_n;
				if (s_tlast) begin
					cnt_q       <= '0;
					drain_cnt_q <= rsenc_pkg::DRAIN_W'(NPAR - 1);
				end else begin
					cnt_q <= cnt_inc;
				end
			end else if (drain_step) begin
				if (drain_done) begin
					err_q <= 1'b0;
				end else begin
					drain_cnt_q <= drain_cnt_q - 1'b1;
				end
			end
		end
	end

	// LFSR cell row; while draining it acts as a plain shift register
	assign fb = s_tdata ^ par[NPAR-1];

	for (genvar j = 0; j < NPAR; j++) begin : g_cell
		logic [SYM_W-1:0] prev;
		if (j == 0) begin : g_first
			assign prev = '0;
		end else begin : g_rest
			assign prev = par[j-1];
		end
		rsenc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (push),
			.mul_en (acc),
			.fb     (fb),
			.coef   (rsenc_pkg::GEN_COEF[j]),
			.prev   (prev),
			.q      (par[j])
		);
	end

	// result item for this cycle
	always_comb begin
		if (drain_step) begin
			push_item.symbol    = par[NPAR-1];
			push_item.is_parity = 1'b1;
			push_item.word_end  = (drain_cnt_q == '0);
			push_item.overlong  = err_q;
		end else begin
			push_item.symbol    = s_tdata;
			push_item.is_parity = 1'b0;
			push_item.word_end  = 1'b0;
			push_item.overlong  = err_n;
		end
	end

	rsenc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = out_item.symbol;
	assign m_tuser = {out_item.overlong, out_item.is_parity};
	assign m_tlast = out_item.word_end;

`ifndef SYNTHESIS
	// the final parity shift leaves the cell row cleared
	a_clear_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> (par == '0))
		else $error("LFSR not cleared after parity drain");

	// the symbol count restarts before parity goes out
	a_cnt_zero_in_parity: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsenc_pkg::ST_PARITY) |-> (cnt_q == '0))
		else $error("symbol count not cleared during parity drain");

	// only a parity item can end a codeword
	a_end_is_parity: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[0])
		else $error("word end on a non-parity item");
`endif

endmodule
`default_nettype wire

>>> test/rs_codeword_checker.sv
// Codeword checker: predicts the encoder's output stream and compares it item by item.
`timescale 1ns / 1ps
`default_nettype none
module rs_codeword_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] msg_symbol
	input  wire logic       s_tlast,   // msg_last
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,   // [7:0] out_symbol
	input  wire logic [1:0] m_tuser,   // [0] is_parity, [1] overlong
	input  wire logic       m_tlast,   // word_end
	output int              mismatches,
	output int              pending
);

	logic [7:0]       alog_lut [0:254];
	logic [7:0]       log_lut  [0:255];
	logic [7:0]       gen_poly [0:rsenc_pkg::NPAR];
	logic [7:0]       remainder [0:rsenc_pkg::NPAR-1];
	logic [7:0]       msg_len;
	logic             too_long;
	rsenc_pkg::item_t codeword_q [$];

	// GF(2^8) product through log / antilog lookup
	function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
		if (a == 8'h00 || b == 8'h00) begin
			return 8'h00;
		end
		return alog_lut[(int'(log_lut[a]) + int'(log_lut[b])) % 255];
	endfunction

	// field tables, then g(x) = (x + a^0)(x + a^1)...(x + a^(NPAR-1))
	initial begin
		logic [8:0] v;
		v = 9'h001;
		for (int i = 0; i < 255; i++) begin
			alog_lut[i]     = v[7:0];
			log_lut[v[7:0]] = 8'(i);
			v = {v[7:0], 1'b0};
			if (v[8]) begin
				v = v ^ {1'b1, rsenc_pkg::GF_POLY};
			end
		end
		log_lut[0] = 8'h00;
		for (int j = 0; j <= rsenc_pkg::NPAR; j++) begin
			gen_poly[j] = (j == 0) ? 8'h01 : 8'h00;
		end
		for (int i = 0; i < rsenc_pkg::NPAR; i++) begin
			for (int j = i + 1; j >= 1; j--) begin
				gen_poly[j] = gen_poly[j-1] ^ gf_product(gen_poly[j], alog_lut[i]);
			end
			gen_poly[0] = gf_product(gen_poly[0], alog_lut[i]);
		end
	end

	task automatic clear_word_state();
		for (int j = 0; j < rsenc_pkg::NPAR; j++) begin
			remainder[j] = 8'h00;
		end
		msg_len  = 8'h00;
		too_long = 1'b0;
	endtask

	// one message symbol: passthrough, LFSR step, parity drain on the last one
	task automatic encode_symbol(input logic [7:0] sym, input logic last);
		logic [7:0]       fb;
		rsenc_pkg::item_t res;
		if (msg_len != rsenc_pkg::CNT_SAT) begin
			msg_len = msg_len + 8'd1;
		end
		if (int'(msg_len) > 255 - rsenc_pkg::NPAR) begin
			too_long = 1'b1;
		end
		fb = sym ^ remainder[rsenc_pkg::NPAR-1];
		for (int j = rsenc_pkg::NPAR - 1; j >= 1; j--) begin
			remainder[j] = remainder[j-1] ^ gf_product(fb, gen_poly[j]);
		end
		remainder[0] = gf_product(fb, gen_poly[0]);
		res = '{symbol: sym, is_parity: 1'b0, word_end: 1'b0, overlong: too_long};
		codeword_q.push_back(res);
		if (last) begin
			for (int j = rsenc_pkg::NPAR - 1; j >= 0; j--) begin
				res = '{symbol: remainder[j], is_parity: 1'b1, word_end: (j == 0),
					overlong: too_long};
				codeword_q.push_back(res);
			end
			clear_word_state();
		end
	endtask

	// inputs are predicted before outputs are matched at the same edge
	always @(posedge clk or negedge arst_n) begin
		rsenc_pkg::item_t want;
		if (!arst_n) begin
			clear_word_state();
			codeword_q.delete();
			mismatches = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_symbol(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (codeword_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item: expected none, %s sym=%h par=%b end=%b ovl=%b",
						$time, "actual", m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
				end else begin
					want = codeword_q.pop_front();
					if (m_tdata !== want.symbol || m_tuser[0] !== want.is_parity ||
						m_tlast !== want.word_end || m_tuser[1] !== want.overlong) begin
						mismatches++;
						$display("%0t: mismatch: expected sym=%h par=%b end=%b ovl=%b,",
							$time, want.symbol, want.is_parity, want.word_end,
							want.overlong);
						$display("%0t:           actual   sym=%h par=%b end=%b ovl=%b",
							$time, m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
					end
				end
			end
		end
		pending = codeword_q.size();
	end

endmodule
`default_nettype wire

>>> test/testbench.sv
// Top of the encoder regression: clock, reset, stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	localparam int RANDOM_ITEMS  = 430;
	// long enough to pass 255-NPAR and to saturate the symbol count
	localparam int LONG_MSG_LEN  = 258;
	localparam int LONG_MSG_WORD = 10;
	localparam int SETTLE_CYCLES = 3 * rsenc_pkg::NPAR + 8;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tready = 1'b0;
	wire        s_tready;
	wire        m_tvalid;
	wire  [7:0] m_tdata;
	wire  [1:0] m_tuser;
	wire        m_tlast;

	int mismatches;
	int pending;
	int idle_pct  = 0;
	int stall_pct = 0;

	rs_gf256_systematic_encoder_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	rs_codeword_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// one symbol, with random idle cycles ahead of it; returns at a falling edge
	task automatic send_symbol(input logic [7:0] sym, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_word(input logic [7:0] syms [$]);
		foreach (syms[k]) begin
			send_symbol(syms[k], k == syms.size() - 1);
		end
	endtask

	// symbols weighted toward the field extremes
	function automatic logic [7:0] pick_symbol();
		int roll;
		roll = $urandom_range(99);
		if (roll < 12) begin
			return 8'h00;
		end
		if (roll < 24) begin
			return 8'hff;
		end
		return 8'($urandom_range(255));
	endfunction

	initial begin
		logic [7:0] word_syms [$];
		int         sent;
		int         word_idx;
		int         len;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero word, all-ones word, walking ones, mixed patterns
		send_word('{8'h00});
		send_word('{8'hff});
		send_word('{8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01});
		send_word('{8'haa, 8'h55, 8'hff, 8'h00});
		send_word('{8'h7f, 8'hfe});
		send_word('{8'h00, 8'h00, 8'h01});

		// random words; the idle and stall pattern rotates every four words
		sent     = 0;
		word_idx = 0;
		while (sent < RANDOM_ITEMS) begin
			case ((word_idx / 4) % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 56;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 56;
				end
				default: begin
					idle_pct  = 13;
					stall_pct = 13;
				end
			endcase
			if (word_idx == LONG_MSG_WORD) begin
				len = LONG_MSG_LEN;
			end else if ($urandom_range(9) == 0) begin
				len = $urandom_range(17, 40);
			end else begin
				len = $urandom_range(1, 12);
			end
			word_syms.delete();
			repeat (len) begin
				word_syms.push_back(pick_symbol());
			end
			send_word(word_syms);
			sent += len;
			word_idx++;
		end
		s_tvalid <= 1'b0;

		// drain, then watch for stray items
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/rsenc_pkg.sv
hw/rtl/rsenc_cell.sv
hw/rtl/rsenc_out_buf.sv
hw/rtl/rs_gf256_systematic_encoder_core.sv
test/rs_codeword_checker.sv
test/testbench.sv
